// ----- rtl/ssab_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ssab_pkg;

  localparam int FRAC_BITS = 16;
  localparam int REG_W     = 21;
  localparam int CFG_IDX_W = 2;

  localparam logic [REG_W-1:0] STEP_TIME_RST    = 21'd1092;
  localparam logic [REG_W-1:0] CONTACT_SKIN_RST = 21'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_TIME    = 2'd0,
    CFG_CONTACT_SKIN = 2'd1
  } cfg_reg_t;

  // one body as it travels down the pipe
  typedef struct packed {
    logic [2:0][31:0] start;
    logic [2:0][31:0] move;
    logic [30:0]      radius;
    logic             fixed;
  } body_t;

  // clamp the full velocity * step product (already shifted) to 32 signed bits
  function automatic logic [31:0] sat_move(input logic signed [53:0] v);
    logic [31:0] r;
    if (v[53:31] == {23{v[53]}}) begin
      r = v[31:0];
    end else if (v[53]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

  // clamp a box bound to 32 signed bits
  function automatic logic [31:0] sat_bound(input logic signed [33:0] v);
    logic [31:0] r;
    if (v[33:31] == {3{v[33]}}) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ssab_disp.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Stages 1-2: velocity * step time, then shift and clamp; padded radius.
module ssab_disp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_vld,
  input  wire logic [2:0][31:0]            in_start,
  input  wire logic [2:0][31:0]            in_vel,
  input  wire logic                        in_fixed,
  input  wire logic [30:0]                 in_radius,
  input  wire logic [ssab_pkg::REG_W-1:0]  step_time,
  input  wire logic [ssab_pkg::REG_W-1:0]  contact_skin,
  output logic                             out_vld,
  output ssab_pkg::body_t                  out_body
);

  logic                    v1_r;
  logic signed [53:0]      prod_r [3];
  logic signed [53:0]      prod_nxt [3];
  logic [2:0][31:0]        start1_r;
  logic                    fixed1_r;
  logic [30:0]             radius1_r;
  logic [30:0]             radius1_nxt;
  logic [31:0]             rsum;

  logic                    v2_r;
  ssab_pkg::body_t         body2_r;
  ssab_pkg::body_t         body2_nxt;
  logic signed [53:0]      shifted [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_nxt[k] = $signed(in_vel[k]) * $signed({1'b0, step_time});
    end
    rsum = {1'b0, in_radius} + {11'b0, contact_skin};
    radius1_nxt = rsum[31] ? 31'h7fff_ffff : rsum[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      prod_r[k] <= prod_nxt[k];
    end
    start1_r  <= in_start;
    fixed1_r  <= in_fixed;
    radius1_r <= radius1_nxt;
  end

  always_comb begin
    body2_nxt.start  = start1_r;
    body2_nxt.radius = radius1_r;
    body2_nxt.fixed  = fixed1_r;
    for (int k = 0; k < 3; k++) begin
      // arithmetic shift floors toward minus infinity
      shifted[k]        = prod_r[k] >>> ssab_pkg::FRAC_BITS;
      body2_nxt.move[k] = ssab_pkg::sat_move(shifted[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    body2_r <= body2_nxt;
  end

  assign out_vld  = v2_r;
  assign out_body = body2_r;

endmodule

`default_nettype wire

// ----- rtl/ssab_sweep.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Stages 3-5: squared move length against squared padded radius; fixed bodies never sweep.
module ssab_sweep (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_vld,
  input  wire ssab_pkg::body_t  in_body,
  output logic                  out_vld,
  output ssab_pkg::body_t       out_body,
  output logic                  out_swept
);

  logic [31:0]      mag [3];
  logic [63:0]      sq_nxt [3];
  logic [63:0]      sq_r [3];
  logic [61:0]      rsq_nxt;
  logic [61:0]      rsq3_r;
  logic             v3_r;
  ssab_pkg::body_t  body3_r;

  logic [63:0]      sum_nxt;
  logic [63:0]      sum_r;
  logic [61:0]      rsq4_r;
  logic             v4_r;
  ssab_pkg::body_t  body4_r;

  logic             swept_nxt;
  logic             swept5_r;
  logic             v5_r;
  ssab_pkg::body_t  body5_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k]    = in_body.move[k][31] ? (~in_body.move[k] + 32'd1) : in_body.move[k];
      sq_nxt[k] = {32'b0, mag[k]} * {32'b0, mag[k]};
    end
    rsq_nxt = {31'b0, in_body.radius} * {31'b0, in_body.radius};
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq_r[k] <= sq_nxt[k];
    end
    rsq3_r  <= rsq_nxt;
    body3_r <= in_body;
  end

  // three squares of at most 2^62 each: sum fits 64 bits
  assign sum_nxt = sq_r[0] + sq_r[1] + sq_r[2];

  always_ff @(posedge clk) begin
    sum_r   <= sum_nxt;
    rsq4_r  <= rsq3_r;
    body4_r <= body3_r;
  end

  assign swept_nxt = !body4_r.fixed && (sum_r > {2'b0, rsq4_r});

  always_ff @(posedge clk) begin
    swept5_r <= swept_nxt;
    body5_r  <= body4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v3_r <= in_vld;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  assign out_vld   = v5_r;
  assign out_body  = body5_r;
  assign out_swept = swept5_r;

endmodule

`default_nettype wire

// ----- rtl/ssab_bounds.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Stage 6: end point, box bounds widened by the radius, output registers.
module ssab_bounds (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_vld,
  input  wire ssab_pkg::body_t  in_body,
  input  wire logic             in_swept,
  output logic                  out_vld,
  output logic [2:0][31:0]      out_min,
  output logic [2:0][31:0]      out_max,
  output logic [2:0][31:0]      out_move,
  output logic [30:0]           out_radius,
  output logic                  out_swept
);

  logic signed [32:0] st [3];
  logic signed [32:0] fin [3];
  logic signed [32:0] lo_base [3];
  logic signed [32:0] hi_base [3];
  logic signed [33:0] rad_s;
  logic signed [33:0] lo [3];
  logic signed [33:0] hi [3];
  logic [2:0][31:0]   min_nxt;
  logic [2:0][31:0]   max_nxt;

  logic               vld_r;
  logic [2:0][31:0]   min_r;
  logic [2:0][31:0]   max_r;
  logic [2:0][31:0]   move_r;
  logic [30:0]        radius_r;
  logic               swept_r;

  always_comb begin
    rad_s = $signed({3'b0, in_body.radius});
    for (int k = 0; k < 3; k++) begin
      st[k]  = $signed({in_body.start[k][31], in_body.start[k]});
      fin[k] = st[k] + $signed({in_body.move[k][31], in_body.move[k]});
      // end lies below start exactly when the move is negative
      lo_base[k] = (in_swept && in_body.move[k][31]) ? fin[k] : st[k];
      hi_base[k] = (in_swept && !in_body.move[k][31]) ? fin[k] : st[k];
      lo[k] = $signed({lo_base[k][32], lo_base[k]}) - rad_s;
      hi[k] = $signed({hi_base[k][32], hi_base[k]}) + rad_s;
      min_nxt[k] = ssab_pkg::sat_bound(lo[k]);
      max_nxt[k] = ssab_pkg::sat_bound(hi[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    min_r    <= min_nxt;
    max_r    <= max_nxt;
    move_r   <= in_body.move;
    radius_r <= in_body.radius;
    swept_r  <= in_swept;
  end

  assign out_vld    = vld_r;
  assign out_min    = min_r;
  assign out_max    = max_r;
  assign out_move   = move_r;
  assign out_radius = radius_r;
  assign out_swept  = swept_r;

endmodule

`default_nettype wire

// ----- rtl/swept_sphere_aabb_builder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Swept-sphere bounding box builder. One body enters per clock whenever start
// is high; busy is always low, so a new transaction can follow every cycle.
// Each body yields exactly one result at the end of the pipeline, shown for a single
// cycle with out_valid high; the receiver cannot hold results off, so it must
// take every strobed result. The pipeline stages are, in order:
// velocity multiply, shift and clamp, squaring, sum, sweep compare, box bounds.
// Configuration writes via cfg_we take effect at once and belong in idle gaps.
module swept_sphere_aabb_builder_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [ssab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ssab_pkg::REG_W-1:0]      cfg_data,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [31:0]                     in_start_x,
  input  wire logic [31:0]                     in_start_y,
  input  wire logic [31:0]                     in_start_z,
  input  wire logic [31:0]                     in_vel_x,
  input  wire logic [31:0]                     in_vel_y,
  input  wire logic [31:0]                     in_vel_z,
  input  wire logic                            in_is_fixed,
  input  wire logic [30:0]                     in_collider_radius,
  output logic                                 out_valid,
  output logic [31:0]                          out_box_min_x,
  output logic [31:0]                          out_box_min_y,
  output logic [31:0]                          out_box_min_z,
  output logic [31:0]                          out_box_max_x,
  output logic [31:0]                          out_box_max_y,
  output logic [31:0]                          out_box_max_z,
  output logic [31:0]                          out_move_x,
  output logic [31:0]                          out_move_y,
  output logic [31:0]                          out_move_z,
  output logic [30:0]                          out_padded_radius,
  output logic                                 out_is_swept
);

  logic [ssab_pkg::REG_W-1:0] step_time_r;
  logic [ssab_pkg::REG_W-1:0] contact_skin_r;

  logic                 acc;
  logic                 disp_vld;
  ssab_pkg::body_t      disp_body;
  logic                 sw_vld;
  ssab_pkg::body_t      sw_body;
  logic                 sw_swept;
  logic [2:0][31:0]     box_min;
  logic [2:0][31:0]     box_max;
  logic [2:0][31:0]     box_move;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r    <= ssab_pkg::STEP_TIME_RST;
      contact_skin_r <= ssab_pkg::CONTACT_SKIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssab_pkg::CFG_STEP_TIME:    step_time_r    <= cfg_data;
        ssab_pkg::CFG_CONTACT_SKIN: contact_skin_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ssab_disp u_disp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (acc),
    .in_start     ({in_start_z, in_start_y, in_start_x}),
    .in_vel       ({in_vel_z, in_vel_y, in_vel_x}),
    .in_fixed     (in_is_fixed),
    .in_radius    (in_collider_radius),
    .step_time    (step_time_r),
    .contact_skin (contact_skin_r),
    .out_vld      (disp_vld),
    .out_body     (disp_body)
  );

  ssab_sweep u_sweep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (disp_vld),
    .in_body   (disp_body),
    .out_vld   (sw_vld),
    .out_body  (sw_body),
    .out_swept (sw_swept)
  );

  ssab_bounds u_bounds (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (sw_vld),
    .in_body    (sw_body),
    .in_swept   (sw_swept),
    .out_vld    (out_valid),
    .out_min    (box_min),
    .out_max    (box_max),
    .out_move   (box_move),
    .out_radius (out_padded_radius),
    .out_swept  (out_is_swept)
  );

  assign out_box_min_x = box_min[0];
  assign out_box_min_y = box_min[1];
  assign out_box_min_z = box_min[2];
  assign out_box_max_x = box_max[0];
  assign out_box_max_y = box_max[1];
  assign out_box_max_z = box_max[2];
  assign out_move_x    = box_move[0];
  assign out_move_y    = box_move[1];
  assign out_move_z    = box_move[2];

endmodule

`default_nettype wire
